[rtl/core/saw_pkg.sv]
`timescale 1ns / 1ps
// saw_pkg: shared types and constants for the stop-and-wait ARQ sender.
// No dependencies; saw_div, saw_oq, the top level and saw_chk import it.
package saw_pkg;

  localparam int unsigned CFG_AW   = 4;    // four 32-bit registers at 4*i
  localparam int unsigned FSIZE_W  = 24;
  localparam int unsigned OQ_DEPTH = 4;
  localparam int unsigned OQ_AW    = $clog2(OQ_DEPTH);
  localparam int unsigned OQ_CW    = $clog2(OQ_DEPTH + 1);
  localparam int unsigned RECIP_SH = 32;   // fixed-point shift of the reciprocal

  localparam logic [7:0]  GIVEUP_RST  = 8'd10;
  localparam logic [23:0] TIMEOUT_RST = 24'd64000;

  typedef enum logic [1:0] {
    REG_START_ADDR = 2'd0,
    REG_FILE_SIZE  = 2'd1,
    REG_GIVEUP     = 2'd2,
    REG_TIMEOUT    = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    CMD_START    = 3'd0,
    CMD_TX_DONE  = 3'd1,
    CMD_ACK      = 3'd2,
    CMD_TIMEOUT  = 3'd3,
    CMD_RX_ERROR = 3'd4
  } cmd_t;

  typedef enum logic [2:0] {
    ACT_FETCH = 3'd0,
    ACT_SEND  = 3'd1,
    ACT_ARM   = 3'd2,
    ACT_DONE  = 3'd3,
    ACT_FAIL  = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_SEND = 2'd1,
    PH_WAIT = 2'd2,
    PH_END  = 2'd3
  } phase_t;

  typedef struct packed {
    act_t        action;
    logic        seq_bit;
    logic [31:0] mem_address;
    logic [8:0]  byte_count;
    logic [23:0] wait_ticks;
    logic [7:0]  retransmit_peak;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [1:0] n;      // number of words pushed this cycle, 0..2
    res_t       a;
    res_t       b;
  } push_t;

  typedef struct packed {
    logic has_room;     // room for two more words
    logic not_empty;
  } oq_stat_t;

endpackage

[rtl/core/saw_in_if.sv]
`timescale 1ns / 1ps
// saw_in_if: event channel into the sender (command plus ACK sequence byte).
// Standalone valid/ready interface; no dependencies.
interface saw_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [7:0] ack_seq;

  modport source (output valid, output command, output ack_seq, input ready);
  modport sink   (input valid, input command, input ack_seq, output ready);
endinterface

[rtl/core/saw_out_if.sv]
`timescale 1ns / 1ps
// saw_out_if: result channel of the sender, one action word per handshake.
// Standalone valid/ready interface; no dependencies.
interface saw_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic        seq_bit;
  logic [31:0] mem_address;
  logic [8:0]  byte_count;
  logic [23:0] wait_ticks;
  logic [7:0]  retransmit_peak;
  logic        last;

  modport source (output valid, output action, output seq_bit, output mem_address,
                  output byte_count, output wait_ticks, output retransmit_peak,
                  output last, input ready);
  modport sink   (input valid, input action, input seq_bit, input mem_address,
                  input byte_count, input wait_ticks, input retransmit_peak,
                  input last, output ready);
endinterface

[rtl/core/saw_div.sv]
`timescale 1ns / 1ps
// saw_div: three-stage divide of the file size by a constant payload size.
// Gives the packet count (ceiling) and the remainder. Depends on saw_pkg.
module saw_div #(
  parameter int unsigned DIVISOR = 255,
  parameter int unsigned QW      = 17
) (
  input  logic                        clk,
  input  logic [saw_pkg::FSIZE_W-1:0] dividend,
  output logic [QW-1:0]               total,
  output logic [7:0]                  rem
);
  import saw_pkg::*;

  localparam longint unsigned RECIP = (64'd1 << RECIP_SH) / DIVISOR;
  localparam int unsigned     MW    = $clog2(RECIP + 1);
  localparam int unsigned     PW    = FSIZE_W + MW;
  localparam int unsigned     QEW   = PW - RECIP_SH;
  localparam logic [MW-1:0]   RECIP_V = MW'(RECIP);
  localparam logic [8:0]      DIV_V   = 9'(DIVISOR);

  logic [PW-1:0]      prod_r;
  logic [FSIZE_W-1:0] fs1_r;
  logic [QEW-1:0]     q_r;
  logic [FSIZE_W-1:0] qp_r;
  logic [FSIZE_W-1:0] fs2_r;
  logic [QW-1:0]      total_r;
  logic [7:0]         rem_r;

  logic [QEW-1:0]     q_est;
  logic [FSIZE_W-1:0] r_full;
  logic [8:0]         r_est;
  logic [8:0]         r_fix;
  logic [QEW-1:0]     q_fix;
  logic [QW-1:0]      total_nxt;

  // floor reciprocal: estimate is exact or one short, so r_est < 2*DIVISOR
  assign q_est = prod_r[PW-1:RECIP_SH];

  always_comb begin
    r_full = fs2_r - qp_r;
    r_est  = r_full[8:0];
    if (r_est >= DIV_V) begin
      r_fix = r_est - DIV_V;
      q_fix = q_r + QEW'(1);
    end else begin
      r_fix = r_est;
      q_fix = q_r;
    end
    total_nxt = QW'(q_fix) + QW'(r_fix != 9'd0);
  end

  always_ff @(posedge clk) begin
    prod_r  <= PW'(dividend) * PW'(RECIP_V);
    fs1_r   <= dividend;
    q_r     <= q_est;
    qp_r    <= FSIZE_W'(q_est) * FSIZE_W'(DIV_V);
    fs2_r   <= fs1_r;
    total_r <= total_nxt;
    rem_r   <= r_fix[7:0];
  end

  assign total = total_r;
  assign rem   = rem_r;

endmodule

[rtl/core/saw_oq.sv]
`timescale 1ns / 1ps
// saw_oq: small register queue holding result words until the sink takes them.
// Accepts up to two words per cycle. Depends on saw_pkg.
module saw_oq (
  input  logic              clk,
  input  logic              rst_n,
  input  saw_pkg::push_t    push,
  input  logic              pop,
  output saw_pkg::res_t     head,
  output saw_pkg::oq_stat_t stat
);
  import saw_pkg::*;

  res_t             q_r [OQ_DEPTH];
  logic [OQ_AW-1:0] head_r, head_nxt;
  logic [OQ_AW-1:0] tail_r, tail_nxt;
  logic [OQ_CW-1:0] cnt_r, cnt_nxt;
  logic [OQ_AW-1:0] tail_p1;

  assign tail_p1 = tail_r + OQ_AW'(1);

  always_comb begin
    head_nxt = pop ? head_r + OQ_AW'(1) : head_r;
    tail_nxt = tail_r + OQ_AW'(push.n);
    cnt_nxt  = cnt_r + OQ_CW'(push.n) - OQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      q_r[tail_r] <= push.a;
    end
    if (push.n == 2'd2) begin
      q_r[tail_p1] <= push.b;
    end
  end

  assign head           = q_r[head_r];
  assign stat.not_empty = (cnt_r != '0);
  assign stat.has_room  = (cnt_r <= OQ_CW'(OQ_DEPTH - 2));

endmodule

[rtl/core/stop_and_wait_arq_sender.sv]
`timescale 1ns / 1ps
// stop_and_wait_arq_sender: alternating-bit sender for a paged file transfer.
// Depends on saw_pkg, saw_in_if, saw_out_if, saw_div and saw_oq.
//
// Events (start, transmit done, ACK, timeout, receive error) arrive as words on
// in_if; each event is handled in the cycle it is accepted and yields zero, one
// or two action words on out_if (fetch+send, arm, send, finished, gave up).
// The last word of each event carries last=1.
// The action words are registered into the result queue and offered behind any earlier words.
// Throughput: one event per cycle while the result queue (four words) has room
// for two more; the sink draining one word a cycle sets the sustained rate.
// Registers sit on an APB-style port at byte addresses 0, 4, 8, 12
// (start address, file size, give-up limit, ACK timeout); pready is tied high.
// The packet count comes from a three-stage constant divider fed by the file
// size register: after reset and after every file size write, in_if.ready
// stays low until the divider result has settled.
// Reset is synchronous and active low; it clears the protocol state, the
// retransmit peak and the result queue, and loads the register defaults.
// When the sink stalls, words wait in the queue and in_if.ready drops once
// fewer than two slots are free; nothing is dropped.
module stop_and_wait_arq_sender #(
  parameter int unsigned PAYLOAD_BYTES = 255,
  parameter int unsigned PAGE_BYTES    = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  saw_in_if.sink                     in_if,
  saw_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [saw_pkg::CFG_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import saw_pkg::*;

  localparam int unsigned TP_W     = $clog2((1 << FSIZE_W) / PAYLOAD_BYTES + 2);
  localparam logic [8:0]  FULL_LEN = 9'(PAGE_BYTES - 2);
  localparam logic [31:0] PAGE_INC = 32'(PAGE_BYTES);

  // configuration
  logic [31:0]        start_addr_r;
  logic [FSIZE_W-1:0] fsize_r;
  logic [7:0]         giveup_r;
  logic [23:0]        timeout_r;
  logic [1:0]         settle_r;
  logic               cfg_wr;
  reg_idx_t           cfg_idx;

  // protocol state
  phase_t             phase_r, phase_nxt;
  logic               seq_r, seq_nxt;
  logic [TP_W-1:0]    done_r, done_nxt;
  logic [TP_W-1:0]    total_r, total_nxt;
  logic [31:0]        page_r, page_nxt;
  logic [7:0]         retry_r, retry_nxt;
  logic [7:0]         peak_r, peak_nxt;
  logic               waited_r, waited_nxt;

  logic [TP_W-1:0]    div_total;
  logic [7:0]         div_rem;
  logic               in_fire;
  logic               emit;
  logic               fetch;
  act_t               act0;
  logic [8:0]         fetch_len;
  logic               last_pkt;
  logic [TP_W:0]      done_p1;
  push_t              push;
  res_t               head;
  oq_stat_t           oq_stat;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      REG_START_ADDR: prdata = start_addr_r;
      REG_FILE_SIZE:  prdata = 32'(fsize_r);
      REG_GIVEUP:     prdata = 32'(giveup_r);
      REG_TIMEOUT:    prdata = 32'(timeout_r);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_addr_r <= '0;
      fsize_r      <= '0;
      giveup_r     <= GIVEUP_RST;
      timeout_r    <= TIMEOUT_RST;
      settle_r     <= 2'd3;
    end else begin
      if (settle_r != 2'd0) begin
        settle_r <= settle_r - 2'd1;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_START_ADDR: start_addr_r <= pwdata;
          REG_FILE_SIZE: begin
            fsize_r  <= pwdata[FSIZE_W-1:0];
            settle_r <= 2'd3;
          end
          REG_GIVEUP:     giveup_r  <= pwdata[7:0];
          REG_TIMEOUT:    timeout_r <= pwdata[23:0];
          default: ;
        endcase
      end
    end
  end

  saw_div #(
    .DIVISOR (PAYLOAD_BYTES),
    .QW      (TP_W)
  ) u_div (
    .clk      (clk),
    .dividend (fsize_r),
    .total    (div_total),
    .rem      (div_rem)
  );

  assign in_if.ready = (settle_r == 2'd0) && oq_stat.has_room;
  assign in_fire     = in_if.valid && in_if.ready;

  function automatic res_t mk_res(act_t act, logic seq, logic [31:0] addr,
                                  logic [8:0] cnt, logic [23:0] ticks,
                                  logic [7:0] peak, logic lst);
    res_t r;
    r.action          = act;
    r.seq_bit         = seq;
    r.mem_address     = addr;
    r.byte_count      = cnt;
    r.wait_ticks      = ticks;
    r.retransmit_peak = peak;
    r.last            = lst;
    return r;
  endfunction

  always_comb begin
    phase_nxt  = phase_r;
    seq_nxt    = seq_r;
    done_nxt   = done_r;
    total_nxt  = total_r;
    page_nxt   = page_r;
    retry_nxt  = retry_r;
    peak_nxt   = peak_r;
    waited_nxt = waited_r;
    emit       = 1'b0;
    fetch      = 1'b0;
    act0       = ACT_DONE;
    done_p1    = {1'b0, done_r} + (TP_W + 1)'(1);

    if (in_fire) begin
      priority case (in_if.command)
        CMD_START: begin
          total_nxt  = div_total;
          page_nxt   = start_addr_r;
          seq_nxt    = 1'b0;
          done_nxt   = '0;
          retry_nxt  = '0;
          waited_nxt = 1'b0;
          emit       = 1'b1;
          if (div_total == '0) begin
            act0      = ACT_DONE;
            phase_nxt = PH_END;
          end else begin
            fetch     = 1'b1;
            phase_nxt = PH_SEND;
          end
        end
        CMD_TX_DONE: begin
          if (phase_r == PH_SEND) begin
            emit      = 1'b1;
            act0      = ACT_ARM;
            phase_nxt = PH_WAIT;
          end
        end
        CMD_ACK, CMD_RX_ERROR: begin
          if (phase_r == PH_WAIT) begin
            emit = 1'b1;
            if (in_if.command == CMD_ACK && in_if.ack_seq == {7'd0, seq_r}) begin
              if (retry_r > peak_r) begin
                peak_nxt = retry_r;
              end
              retry_nxt = '0;
              done_nxt  = done_p1[TP_W-1:0];
              if (done_p1 >= {1'b0, total_r}) begin
                act0      = ACT_DONE;
                phase_nxt = PH_END;
              end else begin
                page_nxt   = page_r + PAGE_INC;
                seq_nxt    = ~seq_r;
                waited_nxt = 1'b0;
                fetch      = 1'b1;
                phase_nxt  = PH_SEND;
              end
            end else begin
              // wrong ACK or receive error: re-arm and keep waiting
              waited_nxt = 1'b1;
              act0       = ACT_ARM;
            end
          end
        end
        CMD_TIMEOUT: begin
          if (phase_r == PH_WAIT) begin
            emit = 1'b1;
            if (waited_r) begin
              if (retry_r != 8'hFF) begin
                retry_nxt = retry_r + 8'd1;
              end
              if (retry_nxt > peak_r) begin
                peak_nxt = retry_nxt;
              end
            end
            waited_nxt = 1'b1;
            if (retry_nxt < giveup_r) begin
              act0      = ACT_SEND;
              phase_nxt = PH_SEND;
            end else begin
              act0      = ACT_FAIL;
              phase_nxt = PH_END;
            end
          end
        end
        default: ;
      endcase
    end

    // short final packet takes the live remainder, capped at FULL_LEN (PAGE_BYTES - 2)
    last_pkt = ({1'b0, done_nxt} + (TP_W + 1)'(1) == {1'b0, total_nxt})
               && (div_rem != 8'd0);
    if (last_pkt && (9'(div_rem) < FULL_LEN)) begin
      fetch_len = 9'(div_rem);
    end else begin
      fetch_len = FULL_LEN;
    end

    push.n = fetch ? 2'd2 : {1'b0, emit};
    if (fetch) begin
      push.a = mk_res(ACT_FETCH, seq_nxt, page_nxt + 32'd2, fetch_len, 24'd0,
                      peak_nxt, 1'b0);
    end else begin
      push.a = mk_res(act0, seq_nxt, 32'd0, 9'd0,
                      (act0 == ACT_ARM) ? timeout_r : 24'd0, peak_nxt, 1'b1);
    end
    push.b = mk_res(ACT_SEND, seq_nxt, 32'd0, 9'd0, 24'd0, peak_nxt, 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      seq_r    <= 1'b0;
      done_r   <= '0;
      total_r  <= '0;
      page_r   <= '0;
      retry_r  <= '0;
      peak_r   <= '0;
      waited_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      seq_r    <= seq_nxt;
      done_r   <= done_nxt;
      total_r  <= total_nxt;
      page_r   <= page_nxt;
      retry_r  <= retry_nxt;
      peak_r   <= peak_nxt;
      waited_r <= waited_nxt;
    end
  end

  saw_oq u_oq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (out_if.valid && out_if.ready),
    .head  (head),
    .stat  (oq_stat)
  );

  assign out_if.valid           = oq_stat.not_empty;
  assign out_if.action          = head.action;
  assign out_if.seq_bit         = head.seq_bit;
  assign out_if.mem_address     = head.mem_address;
  assign out_if.byte_count      = head.byte_count;
  assign out_if.wait_ticks      = head.wait_ticks;
  assign out_if.retransmit_peak = head.retransmit_peak;
  assign out_if.last            = head.last;

endmodule

[rtl/core/saw_chk.sv]
`timescale 1ns / 1ps
// saw_chk: port-level checks of the ARQ sender, bound to the top level.
// Depends on saw_pkg and stop_and_wait_arq_sender.
module saw_chk (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [2:0]                 out_action,
  input logic [31:0]                out_mem_address,
  input logic                       out_last,
  input logic                       psel,
  input logic                       penable,
  input logic                       pwrite,
  input logic [saw_pkg::CFG_AW-1:0] paddr
);
  import saw_pkg::*;

  // protocol: a stalled word stays offered, with action and address unchanged
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_action) && $stable(out_mem_address))
    else $error("result word changed while stalled");

  // reset leaves the divider settling and the queue empty: no event taken, no word offered
  a_rst_settle: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not quiet after reset");

  // a file size write restarts the divider settle window
  a_fsize_settle: assert property (@(posedge clk) disable iff (!rst_n)
    psel && penable && pwrite && (paddr[CFG_AW-1:2] == REG_FILE_SIZE) |=> !in_ready)
    else $error("event accepted while packet count settles");

  // a fetch word is never the last word of its event; its send follows it
  a_fetch_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_action == ACT_FETCH) |-> !out_last)
    else $error("fetch word marked last");

endmodule

bind stop_and_wait_arq_sender saw_chk u_saw_chk (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .out_action      (out_if.action),
  .out_mem_address (out_if.mem_address),
  .out_last        (out_if.last),
  .psel            (psel),
  .penable         (penable),
  .pwrite          (pwrite),
  .paddr           (paddr)
);
